[rtl/eul_pkg.sv]
// Shared types, constants and fixed-point helpers for the Euler-to-rotation-matrix block.
`timescale 1ns / 1ps
`default_nettype none
package eul_pkg;

  typedef logic signed [32:0] q30_t;

  localparam q30_t ONE_Q30 = 33'sd1073741824;
  localparam q30_t C1 = 33'sd1686629713;
  localparam q30_t C3 = -33'sd693598668;
  localparam q30_t C5 = 33'sd85569306;
  localparam q30_t C7 = -33'sd5026996;
  localparam q30_t C9 = 33'sd172271;

  localparam int SIN_LAT = 7;
  localparam int MAT_LAT = 3;
  localparam int TOTAL_LAT = SIN_LAT + MAT_LAT;

  localparam logic [31:0] QUARTER_TURN = 32'h4000_0000;

  function automatic q30_t q30_mul(input q30_t a, input q30_t b);
    logic signed [65:0] p;
    logic [65:0] m;
    logic [65:0] r;
    p = 66'(a) * 66'(b);
    m = p[65] ? 66'(-p) : 66'(p);
    r = (m + (66'd1 << 29)) >> 30;
    q30_mul = p[65] ? -$signed(r[32:0]) : $signed(r[32:0]);
  endfunction

endpackage
`default_nettype wire

[rtl/eul_sin.sv]
// Pipelined polynomial sine of a 32-bit phase, Q30 result.
`timescale 1ns / 1ps
`default_nettype none
module eul_sin (
  input  wire logic          clk,
  input  wire logic          en,
  input  wire logic [31:0]   phase,
  output eul_pkg::q30_t      sine
);

  logic [1:0]     quad [0:5];
  eul_pkg::q30_t  z    [0:5];
  eul_pkg::q30_t  z2   [1:4];
  eul_pkg::q30_t  t    [2:5];
  eul_pkg::q30_t  s_raw;
  eul_pkg::q30_t  s_clamp;
  eul_pkg::q30_t  z_in;

  always_comb begin
    z_in = eul_pkg::q30_t'({3'b000, phase[29:0]});
    if (phase[30]) begin
      z_in = eul_pkg::ONE_Q30 - z_in;
    end
  end

  always_comb begin
    s_raw = eul_pkg::q30_mul(z[5], t[5]);
    s_clamp = s_raw;
    if (s_raw < 0) begin
      s_clamp = '0;
    end else if (s_raw > eul_pkg::ONE_Q30) begin
      s_clamp = eul_pkg::ONE_Q30;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      quad[0] <= phase[31:30];
      z[0]    <= z_in;
      for (int i = 1; i < 6; i++) begin
        quad[i] <= quad[i-1];
        z[i]    <= z[i-1];
      end
      z2[1] <= eul_pkg::q30_mul(z[0], z[0]);
      for (int i = 2; i < 5; i++) begin
        z2[i] <= z2[i-1];
      end
      t[2]  <= eul_pkg::C7 + eul_pkg::q30_mul(z2[1], eul_pkg::C9);
      t[3]  <= eul_pkg::C5 + eul_pkg::q30_mul(z2[2], t[2]);
      t[4]  <= eul_pkg::C3 + eul_pkg::q30_mul(z2[3], t[3]);
      t[5]  <= eul_pkg::C1 + eul_pkg::q30_mul(z2[4], t[4]);
      sine  <= quad[5][1] ? -s_clamp : s_clamp;
    end
  end

endmodule
`default_nettype wire

[rtl/eul_mat.sv]
// Pipelined products, sums and coefficient rounding of the rotation matrix.
`timescale 1ns / 1ps
`default_nettype none
module eul_mat #(
  parameter int COEFF_WIDTH = 16
) (
  input  wire logic                        clk,
  input  wire logic                        en,
  input  wire eul_pkg::q30_t               sr,
  input  wire eul_pkg::q30_t               cr,
  input  wire eul_pkg::q30_t               sp,
  input  wire eul_pkg::q30_t               cp,
  input  wire eul_pkg::q30_t               sy,
  input  wire eul_pkg::q30_t               cy,
  output logic [9*COEFF_WIDTH-1:0]         coef
);

  localparam int SH = 32 - COEFF_WIDTH;
  localparam int LIM = 2 ** (COEFF_WIDTH - 2);

  function automatic logic [COEFF_WIDTH-1:0] to_coeff(input eul_pkg::q30_t v);
    logic [33:0] m;
    logic [33:0] r;
    m = v[32] ? 34'(-$signed({v[32], v})) : {1'b0, v};
    r = (m + (34'd1 << (SH - 1))) >> SH;
    if (r > 34'(LIM)) begin
      r = 34'(LIM);
    end
    to_coeff = v[32] ? COEFF_WIDTH'(-r) : COEFF_WIDTH'(r);
  endfunction

  eul_pkg::q30_t cysp, sysp, a00, a10, a21, a22, sycr, cycr, sysr, cysr, sr1, cr1, nsp1;
  eul_pkg::q30_t p01, p11, p02, p12, b00, b10, b21, b22, bsycr, bcycr, bsysr, bcysr, nsp2;

  always_ff @(posedge clk) begin
    if (en) begin
      cysp <= eul_pkg::q30_mul(cy, sp);
      sysp <= eul_pkg::q30_mul(sy, sp);
      a00  <= eul_pkg::q30_mul(cy, cp);
      a10  <= eul_pkg::q30_mul(sy, cp);
      a21  <= eul_pkg::q30_mul(cp, sr);
      a22  <= eul_pkg::q30_mul(cp, cr);
      sycr <= eul_pkg::q30_mul(sy, cr);
      cycr <= eul_pkg::q30_mul(cy, cr);
      sysr <= eul_pkg::q30_mul(sy, sr);
      cysr <= eul_pkg::q30_mul(cy, sr);
      sr1  <= sr;
      cr1  <= cr;
      nsp1 <= -sp;

      p01   <= eul_pkg::q30_mul(cysp, sr1);
      p11   <= eul_pkg::q30_mul(sysp, sr1);
      p02   <= eul_pkg::q30_mul(cysp, cr1);
      p12   <= eul_pkg::q30_mul(sysp, cr1);
      b00   <= a00;
      b10   <= a10;
      b21   <= a21;
      b22   <= a22;
      bsycr <= sycr;
      bcycr <= cycr;
      bsysr <= sysr;
      bcysr <= cysr;
      nsp2  <= nsp1;

      coef <= {to_coeff(b22),
               to_coeff(p12 - bcysr),
               to_coeff(bsysr + p02),
               to_coeff(b21),
               to_coeff(bcycr + p11),
               to_coeff(p01 - bsycr),
               to_coeff(nsp2),
               to_coeff(b10),
               to_coeff(b00)};
    end
  end

endmodule
`default_nettype wire

[rtl/euler_to_rotation_matrix.sv]
// Top level: ZYX Euler angles to rotation matrix, streaming in and out.
//
// Slave channel s_* carries one pose per transfer: roll, pitch and yaw as
// binary angles and an x, y, z translation. Master channel m_* carries the
// nine rotation entries in Q1.14 (COEFF_WIDTH-2 fraction bits) and the
// translation unchanged. Each pose gives exactly one result.
// The pipeline has 10 register stages: m_tvalid rises once the accepted pose
// has passed through all of them, and the result can then be taken.
// The stages are seven of the shared-form sine/cosine pipeline (one
// multiplier per stage on the Horner chain) and three of matrix products,
// sums and rounding.
// Throughput is one pose per cycle. The whole pipeline advances as one
// while the output register is empty or being taken; when the receiver
// holds m_tready low with a result waiting, every stage holds and s_tready
// drops, so nothing is lost or repeated. Reset clears the valid bits only;
// the pipeline is empty and ready right after reset.
`timescale 1ns / 1ps
`default_nettype none
module euler_to_rotation_matrix #(
  parameter int ANGLE_WIDTH = 16,
  parameter int COEFF_WIDTH = 16
) (
  input  wire logic clk,
  input  wire logic rst,
  input  wire logic s_tvalid,
  output logic      s_tready,
  // roll_angle, pitch_angle, yaw_angle, trans_x, trans_y, trans_z, zero pad
  input  wire logic [((3*ANGLE_WIDTH+96+7)/8)*8-1:0] s_tdata,
  output logic      m_tvalid,
  input  wire logic m_tready,
  // r00, r10, r20, r01, r11, r21, r02, r12, r22, out_x, out_y, out_z, zero pad
  output logic [((9*COEFF_WIDTH+96+7)/8)*8-1:0]      m_tdata
);

  localparam int AW = ANGLE_WIDTH;
  localparam int OUT_W = 9 * COEFF_WIDTH + 96;
  localparam int OUT_TW = ((OUT_W + 7) / 8) * 8;
  localparam int LAT = eul_pkg::TOTAL_LAT;

  logic en;
  logic [LAT-1:0] vld;
  logic [95:0] trans [0:LAT-1];
  logic [31:0] ph_r, ph_p, ph_y;
  eul_pkg::q30_t sr, cr, sp, cp, sy, cy;
  logic [9*COEFF_WIDTH-1:0] coef;

  assign en = !vld[LAT-1] || m_tready;
  assign s_tready = en;
  assign m_tvalid = vld[LAT-1];

  assign ph_r = 32'(s_tdata[AW-1:0]) << (32 - AW);
  assign ph_p = 32'(s_tdata[2*AW-1:AW]) << (32 - AW);
  assign ph_y = 32'(s_tdata[3*AW-1:2*AW]) << (32 - AW);

  eul_sin u_sin_r (.clk(clk), .en(en), .phase(ph_r), .sine(sr));
  eul_sin u_cos_r (.clk(clk), .en(en), .phase(ph_r + eul_pkg::QUARTER_TURN), .sine(cr));
  eul_sin u_sin_p (.clk(clk), .en(en), .phase(ph_p), .sine(sp));
  eul_sin u_cos_p (.clk(clk), .en(en), .phase(ph_p + eul_pkg::QUARTER_TURN), .sine(cp));
  eul_sin u_sin_y (.clk(clk), .en(en), .phase(ph_y), .sine(sy));
  eul_sin u_cos_y (.clk(clk), .en(en), .phase(ph_y + eul_pkg::QUARTER_TURN), .sine(cy));

  eul_mat #(.COEFF_WIDTH(COEFF_WIDTH)) u_mat (
    .clk(clk), .en(en),
    .sr(sr), .cr(cr), .sp(sp), .cp(cp), .sy(sy), .cy(cy),
    .coef(coef)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (en) begin
      vld <= {vld[LAT-2:0], s_tvalid};
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      trans[0] <= s_tdata[3*AW+95:3*AW];
      for (int i = 1; i < LAT; i++) begin
        trans[i] <= trans[i-1];
      end
    end
  end

  assign m_tdata = OUT_TW'({trans[LAT-1], coef});

  localparam int LIM = 2 ** (COEFF_WIDTH - 2);

  a_r00_range: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> ($signed(m_tdata[COEFF_WIDTH-1:0]) <= LIM &&
                  $signed(m_tdata[COEFF_WIDTH-1:0]) >= -LIM))
    else $error("r00 outside unit range");

  a_r22_range: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> ($signed(m_tdata[9*COEFF_WIDTH-1:8*COEFF_WIDTH]) <= LIM &&
                  $signed(m_tdata[9*COEFF_WIDTH-1:8*COEFF_WIDTH]) >= -LIM))
    else $error("r22 outside unit range");

  a_hold_on_stall: assert property (@(posedge clk) disable iff (rst)
    !s_tready |=> $stable(vld))
    else $error("pipeline moved while stalled");

endmodule
`default_nettype wire

[test/euler_to_rotation_matrix_chk.sv]
// Checker for the Euler-to-rotation-matrix block: predicts each pose result and compares it.
`timescale 1ns / 1ps
module euler_to_rotation_matrix_chk (
  input  logic         clk,
  input  logic         rst,
  input  logic         s_tvalid,
  input  logic         s_tready,
  input  logic [143:0] s_tdata,
  input  logic         m_tvalid,
  input  logic         m_tready,
  input  logic [239:0] m_tdata,
  output int           fail_count,
  output int           pending
);
  localparam longint SC1 = 64'sd1686629713;
  localparam longint SC3 = -64'sd693598668;
  localparam longint SC5 = 64'sd85569306;
  localparam longint SC7 = -64'sd5026996;
  localparam longint SC9 = 64'sd172271;
  localparam longint UNIT = 64'sd1073741824;

  logic [239:0] matrix_q[$];
  int errors = 0;

  function automatic longint round_mul(longint a, longint b);
    longint p;
    longint m;
    p = a * b;
    m = (p < 0) ? -p : p;
    m = (m + (64'sd1 <<< 29)) >>> 30;
    return (p < 0) ? -m : m;
  endfunction

  function automatic longint phase_sine(logic [31:0] ph);
    longint z;
    longint z2;
    longint t;
    longint s;
    z = longint'({34'd0, ph[29:0]});
    if (ph[30]) z = UNIT - z;
    z2 = round_mul(z, z);
    t = SC9;
    t = SC7 + round_mul(z2, t);
    t = SC5 + round_mul(z2, t);
    t = SC3 + round_mul(z2, t);
    t = SC1 + round_mul(z2, t);
    s = round_mul(z, t);
    if (s < 0) s = 0;
    if (s > UNIT) s = UNIT;
    return ph[31] ? -s : s;
  endfunction

  function automatic logic [15:0] to_q14(longint v);
    longint m;
    m = (v < 0) ? -v : v;
    m = (m + 64'sd32768) >>> 16;
    if (m > 16384) m = 16384;
    return (v < 0) ? 16'(-m) : 16'(m);
  endfunction

  function automatic logic [239:0] pose_matrix(logic [143:0] d);
    logic [31:0] pr;
    logic [31:0] pp;
    logic [31:0] py;
    longint sr, cr, sp, cp, sy, cy, cysp, sysp;
    logic [239:0] r;
    pr = {d[15:0], 16'd0};
    pp = {d[31:16], 16'd0};
    py = {d[47:32], 16'd0};
    sr = phase_sine(pr);
    cr = phase_sine(pr + 32'h4000_0000);
    sp = phase_sine(pp);
    cp = phase_sine(pp + 32'h4000_0000);
    sy = phase_sine(py);
    cy = phase_sine(py + 32'h4000_0000);
    cysp = round_mul(cy, sp);
    sysp = round_mul(sy, sp);
    r = '0;
    r[15:0] = to_q14(round_mul(cy, cp));
    r[31:16] = to_q14(round_mul(sy, cp));
    r[47:32] = to_q14(-sp);
    r[63:48] = to_q14(-round_mul(sy, cr) + round_mul(cysp, sr));
    r[79:64] = to_q14(round_mul(cy, cr) + round_mul(sysp, sr));
    r[95:80] = to_q14(round_mul(cp, sr));
    r[111:96] = to_q14(round_mul(sy, sr) + round_mul(cysp, cr));
    r[127:112] = to_q14(-round_mul(cy, sr) + round_mul(sysp, cr));
    r[143:128] = to_q14(round_mul(cp, cr));
    r[239:144] = d[143:48];
    return r;
  endfunction

  string field_name[12] = '{"r00", "r10", "r20", "r01", "r11", "r21", "r02", "r12", "r22",
                            "out_x", "out_y", "out_z"};

  assign fail_count = errors;
  assign pending = matrix_q.size();

  always @(posedge clk) begin
    logic [239:0] want;
    if (!rst) begin
      if (s_tvalid && s_tready) matrix_q.push_back(pose_matrix(s_tdata));
      if (m_tvalid && m_tready) begin
        if (matrix_q.size() == 0) begin
          $error("unexpected transfer on output: %h", m_tdata);
          errors++;
        end else begin
          want = matrix_q.pop_front();
          for (int i = 0; i < 12; i++) begin
            if (i < 9 && want[i*16 +: 16] !== m_tdata[i*16 +: 16]) begin
              $error("%s: expected %0d, got %0d", field_name[i],
                     $signed(want[i*16 +: 16]), $signed(m_tdata[i*16 +: 16]));
              errors++;
            end else if (i >= 9 && want[144+(i-9)*32 +: 32] !== m_tdata[144+(i-9)*32 +: 32]) begin
              $error("%s: expected %0d, got %0d", field_name[i],
                     $signed(want[144+(i-9)*32 +: 32]), $signed(m_tdata[144+(i-9)*32 +: 32]));
              errors++;
            end
          end
        end
      end
    end
  end
endmodule

[test/euler_to_rotation_matrix_tb.sv]
// Testbench top: drives poses into the Euler-to-rotation-matrix block and reports the verdict.
`timescale 1ns / 1ps
module euler_to_rotation_matrix_tb;
  logic         clk;
  logic         rst;
  logic         s_tvalid;
  logic         s_tready;
  logic [143:0] s_tdata;
  logic         m_tvalid;
  logic         m_tready;
  logic [239:0] m_tdata;
  int           fail_count;
  int           pending;
  int           cycle_count;
  bit           calm;
  bit           hold_off;

  euler_to_rotation_matrix DUT (
    .clk(clk), .rst(rst),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata)
  );

  euler_to_rotation_matrix_chk checker_i (
    .clk(clk), .rst(rst),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata),
    .fail_count(fail_count), .pending(pending)
  );

  initial begin
    clk = 0;
    forever #5 clk = ~clk;
  end

  initial begin
    cycle_count = 0;
    forever begin
      @(posedge clk);
      cycle_count++;
      if (cycle_count > 200000) begin
        $display("RESULT: ERROR");
        $finish;
      end
    end
  end

  initial begin
    m_tready = 0;
    @(negedge rst);
    forever begin
      @(negedge clk);
      if (hold_off) begin
        m_tready <= 0;
      end else if (!calm && $urandom_range(0, 5) == 0) begin
        m_tready <= 0;
        repeat ($urandom_range(1, 10)) @(negedge clk);
        m_tready <= 1;
      end else begin
        m_tready <= 1;
      end
    end
  end

  function automatic logic [15:0] pick_angle();
    case ($urandom_range(0, 5))
      0: return 16'h8000;
      1: return 16'h7FFF;
      2: return 16'(16'h4000 * $urandom_range(0, 3) + $urandom_range(0, 2) - 1);
      default: return 16'($urandom);
    endcase
  endfunction

  task automatic send_pose(logic [15:0] roll, logic [15:0] pitch, logic [15:0] yaw,
                           logic [31:0] tx, logic [31:0] ty, logic [31:0] tz);
    s_tdata <= {tz, ty, tx, yaw, pitch, roll};
    s_tvalid <= 1;
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    @(negedge clk);
  endtask

  task automatic send_random(int n);
    for (int i = 0; i < n; i++) begin
      if (!calm && $urandom_range(0, 4) == 0) begin
        s_tvalid <= 0;
        repeat ($urandom_range(1, 10)) @(negedge clk);
      end
      send_pose(pick_angle(), pick_angle(), pick_angle(), $urandom, $urandom, $urandom);
    end
  endtask

  initial begin
    logic [15:0] corner[8] = '{16'h0000, 16'h4000, 16'h8000, 16'hC000,
                               16'h7FFF, 16'hFFFF, 16'h0001, 16'h2000};
    rst = 1;
    s_tvalid = 0;
    s_tdata = '0;
    calm = 0;
    hold_off = 0;
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst = 0;
    for (int i = 0; i < 8; i++)
      send_pose(corner[i], corner[(i + 3) % 8], corner[(i + 5) % 8],
                32'h8000_0000, 32'h7FFF_FFFF, 32'hFFFF_FFFF);
    send_pose(16'h0000, 16'h0000, 16'h0000, 32'h0, 32'h0, 32'h0);
    send_pose(16'h8000, 16'h8000, 16'h8000, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
    send_random(500);
    s_tvalid <= 0;
    while (pending != 0) @(negedge clk);
    hold_off = 1;
    fork
      begin
        repeat (60) @(negedge clk);
        hold_off = 0;
      end
      send_random(40);
    join
    send_random(700);
    calm = 1;
    send_random(200);
    s_tvalid <= 0;
    while (pending != 0) @(negedge clk);
    repeat (20) @(negedge clk);
    if (fail_count == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end
endmodule

[sim.f]
rtl/eul_pkg.sv
rtl/eul_sin.sv
rtl/eul_mat.sv
rtl/euler_to_rotation_matrix.sv
test/euler_to_rotation_matrix_chk.sv
test/euler_to_rotation_matrix_tb.sv
